// ===== hw/rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// shared types and codes of the bitmap block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int unsigned WORD_BITS  = 64;
    localparam int unsigned WORD_SHIFT = 6;

    localparam logic [11:0] RESERVED_RESET = 12'd10;

    localparam logic [1:0] CMD_FORMAT = 2'd0;
    localparam logic [1:0] CMD_ALLOC  = 2'd1;
    localparam logic [1:0] CMD_FREE   = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_SPACE  = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [1:0] ST_BAD_BLOCK = 2'd3;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] byte_size;
        logic [11:0] block_index;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] block_number;
        logic        last;
        logic [12:0] free_count;
    } t_rsp;

    typedef struct packed {
        logic       take;
        logic       size_step;
        logic       wp_inc;
        logic       sweep_wr;
        logic       word_ld;
        logic       alloc;
        logic       release_blk;
        logic       push;
        logic [1:0] push_status;
    } t_dp_cmd;

    typedef struct packed {
        logic too_big;
        logic size_more;
        logic no_space;
        logic need_zero;
        logic found;
        logic last_alloc;
        logic wp_last;
        logic bad_free;
        logic can_push;
    } t_dp_stat;

endpackage

// ===== hw/rtl/bba_dp.sv =====
// ----------------------------------------------------------------------------
// bba_dp
// used map memory, free count, size rounding, lowest free search, result reg
// ----------------------------------------------------------------------------
module bba_dp #(
    parameter int NUM_BLOCKS  = 4096,
    parameter int BLOCK_BYTES = 4096,
    parameter int MAX_RUN     = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bba_pkg::t_req     i_req,
    input  bba_pkg::t_dp_cmd  i_cmd,
    output bba_pkg::t_dp_stat o_stat,
    input  logic              i_cfg_we,
    input  logic [11:0]       i_cfg_wdata,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output bba_pkg::t_rsp     o_rsp
);
    import bba_pkg::*;

    localparam int WORDS  = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int FW     = AW + WORD_SHIFT;
    localparam int CW     = $clog2(NUM_BLOCKS + 1);
    localparam int NW     = $clog2(MAX_RUN + 1);
    localparam int MAXB   = MAX_RUN * BLOCK_BYTES;
    localparam int ACC_W  = $clog2(MAXB + 1);

    logic [WORD_BITS-1:0]  r_mem [0:WORDS-1];
    logic [WORD_BITS-1:0]  r_rdata;
    logic [WORD_BITS-1:0]  r_word;
    logic [AW-1:0]         r_wp;
    logic [CW-1:0]         r_free;
    logic [CW-1:0]         n_free;
    logic [CW-1:0]         r_fill_res;
    logic [11:0]           r_reserved;
    t_req                  r_req;
    logic [ACC_W-1:0]      r_acc;
    logic [NW-1:0]         r_need;
    logic [NW-1:0]         r_cnt;
    logic                  r_out_valid;
    t_rsp                  r_rsp;

    logic [CW-1:0]         res;
    logic [WORD_BITS-1:0]  pat;
    logic [31:0]           base;
    logic [31:0]           diff;
    logic [WORD_BITS-1:0]  inv;
    logic [WORD_BITS-1:0]  lsb;
    logic [WORD_SHIFT-1:0] k;
    logic [FW-1:0]         addr;
    logic [WORD_SHIFT-1:0] fbit;
    logic                  wr_en;
    logic [WORD_BITS-1:0]  wr_data;
    logic                  last_alloc;
    logic                  can_push;

    assign res = (32'(r_reserved) > 32'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS) : CW'(r_reserved);

    // reserved-prefix pattern for the word under the sweep pointer
    always_comb begin
        base = 32'(r_wp) << WORD_SHIFT;
        diff = 32'(r_fill_res) - base;
        pat  = '0;
        if (32'(r_fill_res) <= base) begin
            pat = '0;
        end else if (diff >= 32'(WORD_BITS)) begin
            pat = '1;
        end else begin
            for (int i = 0; i < WORD_BITS; i++) begin
                pat[i] = (32'(i) < diff);
            end
        end
    end

    // lowest free bit of the held word
    always_comb begin
        inv = ~r_word;
        lsb = inv & (~inv + WORD_BITS'(1));
        k   = '0;
        for (int j = 0; j < WORD_SHIFT; j++) begin
            for (int i = 0; i < WORD_BITS; i++) begin
                if (((i >> j) & 1) == 1) begin
                    k[j] = k[j] | lsb[i];
                end
            end
        end
    end

    assign addr       = {r_wp, k};
    assign fbit       = r_req.block_index[WORD_SHIFT-1:0];
    assign last_alloc = (NW'(r_cnt + 1'b1) == r_need);
    assign can_push   = !r_out_valid || i_rsp_ready;

    assign o_stat.too_big    = 32'(r_req.byte_size) > 32'(MAXB);
    assign o_stat.size_more  = 32'(r_req.byte_size) > 32'(r_acc);
    assign o_stat.no_space   = 32'(r_need) > 32'(r_free);
    assign o_stat.need_zero  = (r_need == '0);
    assign o_stat.found      = (|inv) && (32'(addr) < 32'(NUM_BLOCKS));
    assign o_stat.last_alloc = last_alloc;
    assign o_stat.wp_last    = (r_wp == AW'(WORDS - 1));
    assign o_stat.bad_free   = (32'(r_req.block_index) >= 32'(NUM_BLOCKS)) ||
                               (32'(r_req.block_index) < 32'(res)) || !r_rdata[fbit];
    assign o_stat.can_push   = can_push;

    assign wr_en = i_cmd.sweep_wr || i_cmd.alloc || i_cmd.release_blk;

    always_comb begin
        if (i_cmd.sweep_wr) begin
            wr_data = pat;
        end else if (i_cmd.alloc) begin
            wr_data = r_word | lsb;
        end else begin
            wr_data = r_rdata & ~(WORD_BITS'(1) << fbit);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= wr_data;
        end
        r_rdata <= r_mem[r_wp];
    end

    always_comb begin
        n_free = r_free;
        if (i_cmd.take && i_req.command == CMD_FORMAT) begin
            n_free = CW'(NUM_BLOCKS) - res;
        end else if (i_cmd.alloc) begin
            n_free = r_free - CW'(1);
        end else if (i_cmd.release_blk) begin
            n_free = r_free + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_free      <= CW'(NUM_BLOCKS);
            r_fill_res  <= '0;
            r_reserved  <= RESERVED_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_free <= n_free;
            if (i_cfg_we) begin
                r_reserved <= i_cfg_wdata;
            end
            if (i_cmd.take) begin
                r_wp <= (i_req.command == CMD_FREE) ? AW'(i_req.block_index >> WORD_SHIFT) : '0;
                if (i_req.command == CMD_FORMAT) begin
                    r_fill_res <= res;
                end
            end else if (i_cmd.wp_inc) begin
                r_wp <= r_wp + AW'(1);
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_req  <= i_req;
            r_acc  <= '0;
            r_need <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_cmd.size_step) begin
                r_acc  <= r_acc + ACC_W'(BLOCK_BYTES);
                r_need <= r_need + NW'(1);
            end
            if (i_cmd.alloc) begin
                r_cnt <= r_cnt + NW'(1);
            end
        end
        if (i_cmd.word_ld) begin
            r_word <= r_rdata;
        end else if (i_cmd.alloc) begin
            r_word <= r_word | lsb;
        end
        if (i_cmd.push) begin
            r_rsp.status       <= i_cmd.push_status;
            r_rsp.block_number <= i_cmd.alloc ? 12'(addr) : 12'd0;
            r_rsp.last         <= i_cmd.alloc ? last_alloc : 1'b1;
            r_rsp.free_count   <= 13'(n_free);
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_rsp;

endmodule

// ===== hw/rtl/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bba_ctrl
// sequencer for clear, format, size rounding, word scan and free check
// ----------------------------------------------------------------------------
module bba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  logic [1:0]        i_command,
    input  bba_pkg::t_dp_stat i_stat,
    output bba_pkg::t_dp_cmd  o_cmd
);
    import bba_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_FMT   = 4'd2;
    localparam logic [3:0] S_SIZE  = 4'd3;
    localparam logic [3:0] S_RD    = 4'd4;
    localparam logic [3:0] S_LD    = 4'd5;
    localparam logic [3:0] S_SRCH  = 4'd6;
    localparam logic [3:0] S_FRD   = 4'd7;
    localparam logic [3:0] S_FCHK  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.sweep_wr = 1'b1;
                if (i_stat.wp_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.wp_inc = 1'b1;
                end
            end
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.take = 1'b1;
                    case (i_command)
                        CMD_FORMAT: n_state = S_FMT;
                        CMD_ALLOC:  n_state = S_SIZE;
                        CMD_FREE:   n_state = S_FRD;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_FMT: begin
                o_cmd.sweep_wr = 1'b1;
                if (!i_stat.wp_last) begin
                    o_cmd.wp_inc = 1'b1;
                end else if (i_stat.can_push) begin
                    o_cmd.push        = 1'b1;
                    o_cmd.push_status = ST_OK;
                    n_state           = S_IDLE;
                end
            end
            S_SIZE: begin
                if (i_stat.too_big) begin
                    if (i_stat.can_push) begin
                        o_cmd.push        = 1'b1;
                        o_cmd.push_status = ST_TOO_LARGE;
                        n_state           = S_IDLE;
                    end
                end else if (i_stat.size_more) begin
                    o_cmd.size_step = 1'b1;
                end else if (i_stat.no_space) begin
                    if (i_stat.can_push) begin
                        o_cmd.push        = 1'b1;
                        o_cmd.push_status = ST_NO_SPACE;
                        n_state           = S_IDLE;
                    end
                end else if (i_stat.need_zero) begin
                    if (i_stat.can_push) begin
                        o_cmd.push        = 1'b1;
                        o_cmd.push_status = ST_OK;
                        n_state           = S_IDLE;
                    end
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                o_cmd.word_ld = 1'b1;
                n_state       = S_SRCH;
            end
            S_SRCH: begin
                if (i_stat.found) begin
                    if (i_stat.can_push) begin
                        o_cmd.alloc       = 1'b1;
                        o_cmd.push        = 1'b1;
                        o_cmd.push_status = ST_OK;
                        if (i_stat.last_alloc) begin
                            n_state = S_IDLE;
                        end
                    end
                end else if (i_stat.wp_last) begin
                    if (i_stat.can_push) begin
                        o_cmd.push        = 1'b1;
                        o_cmd.push_status = ST_NO_SPACE;
                        n_state           = S_IDLE;
                    end
                end else begin
                    o_cmd.wp_inc = 1'b1;
                    n_state      = S_RD;
                end
            end
            S_FRD: begin
                n_state = S_FCHK;
            end
            S_FCHK: begin
                if (i_stat.can_push) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                    if (i_stat.bad_free) begin
                        o_cmd.push_status = ST_BAD_BLOCK;
                    end else begin
                        o_cmd.release_blk = 1'b1;
                        o_cmd.push_status = ST_OK;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/bitmap_block_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// first-fit block allocator over a one-bit-per-block used map
// ----------------------------------------------------------------------------
// after reset a clearing pass over every map word runs before the first request
// format: one map word written per cycle, then the result is pushed once the output register has room
// allocate: size rounding, then a read, a load and a search step per map word scanned from word 0,
//   handing out one block per search step while the output register has room
// free: a read step and a check step, bound by the registered read of the map memory
// a result waits in an output register while the next request is taken
module bitmap_block_allocator #(
    parameter int NUM_BLOCKS  = 4096,
    parameter int BLOCK_BYTES = 4096,
    parameter int MAX_RUN     = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  bba_pkg::t_req i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output bba_pkg::t_rsp o_rsp,
    input  logic          i_cfg_we,
    input  logic [11:0]   i_cfg_wdata
);
    import bba_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    bba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_command   (i_req.command),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    bba_dp #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_BYTES (BLOCK_BYTES),
        .MAX_RUN     (MAX_RUN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

endmodule

// ===== dv/bitmap_block_allocator_checker.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator_checker
// watches the request, response and register ports of the block allocator,
// keeps its own used map and free count, and compares every response taken
// by the receiver, field by field, with the oldest predicted one
// ----------------------------------------------------------------------------
module bitmap_block_allocator_checker #(
    parameter int NUM_BLOCKS  = 4096,
    parameter int BLOCK_BYTES = 4096,
    parameter int MAX_RUN     = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  logic          i_req_ready,
    input  bba_pkg::t_req i_req,
    input  logic          i_rsp_valid,
    input  logic          i_rsp_ready,
    input  bba_pkg::t_rsp i_rsp,
    input  logic          i_cfg_we,
    input  logic [11:0]   i_cfg_wdata,
    output int            o_fail_count,
    output int            o_pending,
    output int            o_result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import bba_pkg::*;

    bit          block_used [NUM_BLOCKS];
    int          free_left;
    logic [11:0] reserved_cfg;
    t_rsp        pending_rsp_q [$];
    t_rsp        oldest_rsp;
    bit          rsp_match;
    int          fails;
    int          results;

    initial begin
        fails   = 0;
        results = 0;
    end

    function automatic void clear_allocator();
        for (int b = 0; b < NUM_BLOCKS; b++) begin
            block_used[b] = 1'b0;
        end
        free_left    = NUM_BLOCKS;
        reserved_cfg = RESERVED_RESET;
    endfunction

    function automatic int lowest_free_block();
        for (int b = 0; b < NUM_BLOCKS; b++) begin
            if (!block_used[b]) begin
                return b;
            end
        end
        return NUM_BLOCKS;
    endfunction

    function automatic void queue_rsp(input logic [1:0] st, input int blk, input logic fin);
        t_rsp r;
        r.status       = st;
        r.block_number = blk[11:0];
        r.last         = fin;
        r.free_count   = free_left[12:0];
        pending_rsp_q.push_back(r);
    endfunction

    function automatic void compute_responses(input t_req r);
        int held;
        int need;
        int blk;
        int idx;
        held = (int'(reserved_cfg) > NUM_BLOCKS) ? NUM_BLOCKS : int'(reserved_cfg);
        case (r.command)
            CMD_FORMAT: begin
                for (blk = 0; blk < NUM_BLOCKS; blk++) begin
                    block_used[blk] = (blk < held);
                end
                free_left = NUM_BLOCKS - held;
                queue_rsp(ST_OK, 0, 1'b1);
            end
            CMD_ALLOC: begin
                need = (int'(r.byte_size) + BLOCK_BYTES - 1) / BLOCK_BYTES;
                if (need > MAX_RUN) begin
                    queue_rsp(ST_TOO_LARGE, 0, 1'b1);
                end else if (need > free_left) begin
                    queue_rsp(ST_NO_SPACE, 0, 1'b1);
                end else if (need == 0) begin
                    queue_rsp(ST_OK, 0, 1'b1);
                end else begin
                    for (int j = 0; j < need; j++) begin
                        blk = lowest_free_block();
                        if (blk >= NUM_BLOCKS) begin
                            queue_rsp(ST_NO_SPACE, 0, 1'b1);
                            break;
                        end
                        block_used[blk] = 1'b1;
                        free_left--;
                        queue_rsp(ST_OK, blk, j + 1 == need);
                    end
                end
            end
            CMD_FREE: begin
                idx = int'(r.block_index);
                if (idx >= NUM_BLOCKS || idx < held || !block_used[idx]) begin
                    queue_rsp(ST_BAD_BLOCK, 0, 1'b1);
                end else begin
                    block_used[idx] = 1'b0;
                    free_left++;
                    queue_rsp(ST_OK, 0, 1'b1);
                end
            end
            default: begin
            end
        endcase
    endfunction

    function automatic bit field_ok(input string name, input int unsigned want,
                                    input int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_allocator();
            pending_rsp_q.delete();
        end else begin
            // responses first, a request taken on the same edge is younger
            if (i_rsp_valid && i_rsp_ready) begin
                results++;
                if (pending_rsp_q.size() == 0) begin
                    $error("unexpected response: status %0d block %0d free %0d",
                           i_rsp.status, i_rsp.block_number, i_rsp.free_count);
                    fails++;
                end else begin
                    oldest_rsp = pending_rsp_q.pop_front();
                    rsp_match = field_ok("status", oldest_rsp.status, i_rsp.status)
                              & field_ok("block_number", oldest_rsp.block_number,
                                         i_rsp.block_number)
                              & field_ok("last", oldest_rsp.last, i_rsp.last)
                              & field_ok("free_count", oldest_rsp.free_count,
                                         i_rsp.free_count);
                    if (!rsp_match) begin
                        fails++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                compute_responses(i_req);
            end
            if (i_cfg_we) begin
                reserved_cfg = i_cfg_wdata;
            end
        end
        o_fail_count   <= fails;
        o_pending      <= pending_rsp_q.size();
        o_result_count <= results;
    end

endmodule

// ===== dv/bitmap_block_allocator_test.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator_test
// drives format, allocate, free and unused commands into the block allocator
// under several reserved-block settings, with bursty requests, a stalling
// receiver and one long receiver hold; the checker scores every response
// ----------------------------------------------------------------------------
module bitmap_block_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bba_pkg::*;

    localparam int NUM_BLOCKS      = 4096;
    localparam int BLOCK_BYTES     = 4096;
    localparam int MAX_RUN         = 12;
    localparam int MAX_ALLOC_BYTES = MAX_RUN * BLOCK_BYTES;
    localparam int RESET_CYCLES    = 6;
    localparam int DRAIN_CYCLES    = 300;
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_CYCLES = 4000;
    localparam int PHASE_ITEMS     = 34;

    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_SPARSE} rx_mode_e;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        req_valid   = 1'b0;
    logic        req_ready;
    t_req        req_payload = '0;
    logic        rsp_valid;
    logic        rsp_ready   = 1'b0;
    t_rsp        rsp_data;
    logic        cfg_we      = 1'b0;
    logic [11:0] cfg_wdata   = '0;

    int          chk_fail_count;
    int          chk_pending;
    int          chk_result_count;

    logic [11:0] reserved_now = RESERVED_RESET;
    bit          rx_hold      = 1'b0;
    int          burst_left   = 0;
    int          n_format     = 0;
    int          n_alloc      = 0;
    int          n_free       = 0;
    int          n_ignored    = 0;
    int          n_settings   = 1;

    always #5 i_clk = ~i_clk;

    bitmap_block_allocator #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .BLOCK_BYTES(BLOCK_BYTES),
        .MAX_RUN    (MAX_RUN)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(req_valid),
        .o_req_ready(req_ready),
        .i_req      (req_payload),
        .o_rsp_valid(rsp_valid),
        .i_rsp_ready(rsp_ready),
        .o_rsp      (rsp_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    bitmap_block_allocator_checker #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .BLOCK_BYTES(BLOCK_BYTES),
        .MAX_RUN    (MAX_RUN)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (req_valid),
        .i_req_ready   (req_ready),
        .i_req         (req_payload),
        .i_rsp_valid   (rsp_valid),
        .i_rsp_ready   (rsp_ready),
        .i_rsp         (rsp_data),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .o_fail_count  (chk_fail_count),
        .o_pending     (chk_pending),
        .o_result_count(chk_result_count)
    );

    // bursts of back-to-back requests separated by random gaps
    task automatic pace();
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(12, 1);
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(15, 1);
            if (gap != 0) begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task automatic offer(input logic [1:0] cmd, input logic [15:0] size,
                         input logic [11:0] idx);
        t_req r;
        r.command     = cmd;
        r.byte_size   = size;
        r.block_index = idx;
        pace();
        req_payload <= r;
        req_valid   <= 1'b1;
        do @(posedge i_clk); while (req_ready !== 1'b1);
        case (cmd)
            CMD_FORMAT: n_format++;
            CMD_ALLOC:  n_alloc++;
            CMD_FREE:   n_free++;
            default:    n_ignored++;
        endcase
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        do @(posedge i_clk); while (chk_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reserved(input logic [11:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we       <= 1'b0;
        reserved_now = value;
        n_settings++;
    endtask

    task automatic random_phase(input int n_items);
        int          sent;
        int          pick;
        int          hi;
        logic [15:0] size;
        logic [11:0] idx;
        sent = 0;
        offer(CMD_FORMAT, 16'($urandom), 12'($urandom));
        while (sent < n_items) begin
            pick = $urandom_range(99, 0);
            hi = int'(reserved_now) + 255;
            if (hi > NUM_BLOCKS - 1) begin
                hi = NUM_BLOCKS - 1;
            end
            if (pick < 5) begin
                offer(CMD_UNKNOWN, 16'($urandom), 12'($urandom));
            end else begin
                if (pick < 10) begin
                    offer(CMD_FORMAT, 16'($urandom), 12'($urandom));
                end else if (pick < 55) begin
                    case ($urandom_range(9, 0))
                        0:       size = 16'($urandom);
                        1:       size = '0;
                        default: size = 16'($urandom_range(MAX_ALLOC_BYTES, 1));
                    endcase
                    offer(CMD_ALLOC, size, 12'($urandom));
                end else begin
                    // mostly near the low end where first-fit hands out blocks
                    idx = ($urandom_range(7, 0) == 0) ? 12'($urandom)
                                                      : 12'($urandom_range(hi, reserved_now));
                    offer(CMD_FREE, 16'($urandom), idx);
                end
                sent++;
            end
        end
    endtask

    // receiver
    initial begin
        int       mode_left;
        int       tick;
        rx_mode_e mode;
        mode_left = 0;
        tick      = 0;
        mode      = RX_OPEN;
        forever begin
            @(posedge i_clk);
            if (rx_hold) begin
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rx_hold = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode      = rx_mode_e'($urandom_range(2, 0));
                    mode_left = $urandom_range(80, 20);
                end
                mode_left--;
                tick++;
                case (mode)
                    RX_OPEN:   rsp_ready <= 1'b1;
                    RX_RANDOM: rsp_ready <= ($urandom_range(2, 0) != 0);
                    default:   rsp_ready <= (tick % 4 == 0);
                endcase
            end
        end
    end

    // watchdog
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_CYCLES) begin
            @(posedge i_clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("bitmap_block_allocator_test failed");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // map is clear after reset, so the first request gets block 0
        offer(CMD_ALLOC, 16'd1, 12'd0);
        offer(CMD_FREE, 16'd0, 12'd0);
        offer(CMD_FORMAT, 16'd0, 12'd0);
        offer(CMD_ALLOC, 16'd0, 12'd0);
        offer(CMD_ALLOC, 16'd1, 12'd0);
        offer(CMD_ALLOC, 16'd4096, 12'd0);
        offer(CMD_ALLOC, 16'd4097, 12'd0);
        offer(CMD_ALLOC, 16'(MAX_ALLOC_BYTES), 12'd0);
        offer(CMD_ALLOC, 16'(MAX_ALLOC_BYTES + 1), 12'd0);
        offer(CMD_ALLOC, 16'hffff, 12'hfff);
        offer(CMD_FREE, 16'd0, 12'd5);
        offer(CMD_FREE, 16'd0, 12'd9);
        offer(CMD_FREE, 16'd0, 12'd11);
        offer(CMD_FREE, 16'd0, 12'd11);
        offer(CMD_FREE, 16'hffff, 12'hfff);
        offer(CMD_UNKNOWN, 16'hffff, 12'hfff);
        offer(CMD_ALLOC, 16'd8192, 12'd0);
        offer(CMD_FREE, 16'd0, 12'd10);
        offer(CMD_FORMAT, 16'hffff, 12'hfff);
        settle();

        // one block left after format
        write_reserved(12'd4095);
        offer(CMD_FORMAT, 16'd0, 12'd0);
        offer(CMD_ALLOC, 16'd8192, 12'd0);
        offer(CMD_ALLOC, 16'd1, 12'd0);
        offer(CMD_ALLOC, 16'd1, 12'd0);
        offer(CMD_FREE, 16'd0, 12'hfff);
        offer(CMD_FREE, 16'd0, 12'd4094);
        settle();

        write_reserved(12'd0);
        random_phase(PHASE_ITEMS);
        settle();
        write_reserved(12'd4090);
        random_phase(PHASE_ITEMS);
        settle();
        write_reserved(12'($urandom_range(2000, 11)));
        random_phase(PHASE_ITEMS);
        settle();
        write_reserved(RESERVED_RESET);
        rx_hold = 1'b1;
        random_phase(PHASE_ITEMS);
        settle();
        write_reserved(12'hfff);
        random_phase(PHASE_ITEMS);
        settle();

        $display("covered %0d format, %0d allocate, %0d free and %0d unused-code requests",
                 n_format, n_alloc, n_free, n_ignored);
        $display("scored %0d responses across %0d reserved-block settings",
                 chk_result_count, n_settings);
        if (chk_fail_count == 0 && chk_pending == 0) begin
            $display("bitmap_block_allocator_test passed");
        end else begin
            $display("bitmap_block_allocator_test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/bba_pkg.sv
hw/rtl/bba_dp.sv
hw/rtl/bba_ctrl.sv
hw/rtl/bitmap_block_allocator.sv
dv/bitmap_block_allocator_checker.sv
dv/bitmap_block_allocator_test.sv
